>>> design/octree_node_find_or_insert_assert.svh
// ----------------------------------------------------------------------------
// octree node find-or-insert assertion macros
// Concurrent assertion shorthands used by the datapath; they compile
// to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef OCTREE_NODE_FIND_OR_INSERT_ASSERT_SVH
`define OCTREE_NODE_FIND_OR_INSERT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define OCFI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ocfi assertion failed: same-cycle implication");

// next-cycle implication
`define OCFI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ocfi assertion failed: next-cycle implication");

`else

`define OCFI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OCFI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/ocfi_pkg.sv
// ----------------------------------------------------------------------------
// ocfi_pkg
// Types, constants and codes shared by the octree find-or-insert block.
// ----------------------------------------------------------------------------
package ocfi_pkg;

   // node pool and tree shape
   localparam int POOL_NODES = 4096;
   localparam int MAX_LEVELS = 16;
   localparam int NODE_W     = $clog2(POOL_NODES);
   localparam int COUNT_W    = $clog2(POOL_NODES + 1);
   localparam int OCTANTS    = 8;
   localparam int OCT_W      = 3;

   // field widths
   localparam int COORD_W    = 32;
   localparam int EXTENT_W   = 31;
   localparam int REL_W      = COORD_W + 1;
   localparam int LEVEL_W    = 4;
   localparam int STATUS_W   = 2;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BELOW  = 2'd1,
      ST_BEYOND = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_EXTENT_X = 3'd3,
      REG_EXTENT_Y = 3'd4,
      REG_EXTENT_Z = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic [EXTENT_W-1:0]       extent_x;
      logic [EXTENT_W-1:0]       extent_y;
      logic [EXTENT_W-1:0]       extent_z;
   } cfg_type;

   // one memory row holds the eight child links of a node
   typedef logic [OCTANTS-1:0][NODE_W-1:0] row_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CHECK,
      S_STEP,
      S_EVAL,
      S_LINK,
      S_SPAWN,
      S_RESULT
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       row0_clear;
      logic       walk_init;
      logic       step;
      logic       follow;
      logic       link;
      logic       spawn;
      logic       level_inc;
      logic       emit;
      status_type emit_status;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_clear;
      logic below;
      logic beyond;
      logic hit;
      logic pool_full;
      logic last_level;
      logic out_free;
   } dp_status_type;

endpackage

>>> design/ocfi_if.sv
// ----------------------------------------------------------------------------
// ocfi request and response channels
// Valid/ready channels carrying the request point and the node result.
// ----------------------------------------------------------------------------
interface ocfi_req_if;
   import ocfi_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;
   logic [LEVEL_W-1:0]        target_depth;

   modport source (
      output valid, action, point_x, point_y, point_z, target_depth,
      input  ready
   );

   modport sink (
      input  valid, action, point_x, point_y, point_z, target_depth,
      output ready
   );
endinterface

interface ocfi_rsp_if;
   import ocfi_pkg::*;

   logic                valid;
   logic                ready;
   logic [NODE_W-1:0]   node_index;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, node_index, status,
      input  ready
   );

   modport sink (
      input  valid, node_index, status,
      output ready
   );
endinterface

>>> design/ocfi_csr.sv
// ----------------------------------------------------------------------------
// ocfi_csr
// Tree origin and extent registers, written through the plain write port.
// ----------------------------------------------------------------------------
module ocfi_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [ocfi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ocfi_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output ocfi_pkg::cfg_type                    cfg
);
   import ocfi_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_ORIGIN_X: cfg_in.origin_x = $signed(csr_wdata[COORD_W-1:0]);
            REG_ORIGIN_Y: cfg_in.origin_y = $signed(csr_wdata[COORD_W-1:0]);
            REG_ORIGIN_Z: cfg_in.origin_z = $signed(csr_wdata[COORD_W-1:0]);
            REG_EXTENT_X: cfg_in.extent_x = csr_wdata[EXTENT_W-1:0];
            REG_EXTENT_Y: cfg_in.extent_y = csr_wdata[EXTENT_W-1:0];
            REG_EXTENT_Z: cfg_in.extent_z = csr_wdata[EXTENT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // unit cube at the origin after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.origin_z <= '0;
         cfg_ff.extent_x <= EXTENT_W'(65536);
         cfg_ff.extent_y <= EXTENT_W'(65536);
         cfg_ff.extent_z <= EXTENT_W'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/ocfi_dpath.sv
// ----------------------------------------------------------------------------
// ocfi_dpath
// Point registers, bounds check, per-level octant step, node pool memory,
// allocation counter and the response register.
// ----------------------------------------------------------------------------
`include "octree_node_find_or_insert_assert.svh"

module ocfi_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ocfi_pkg::cfg_type                    cfg,
   input  logic                                 in_action,
   input  logic signed [ocfi_pkg::COORD_W-1:0]  in_point_x,
   input  logic signed [ocfi_pkg::COORD_W-1:0]  in_point_y,
   input  logic signed [ocfi_pkg::COORD_W-1:0]  in_point_z,
   input  logic [ocfi_pkg::LEVEL_W-1:0]         in_target_depth,
   input  logic                                 out_ready,
   output logic                                 out_valid,
   output logic [ocfi_pkg::NODE_W-1:0]          out_node_index,
   output logic [ocfi_pkg::STATUS_W-1:0]        out_status,
   input  ocfi_pkg::dp_cmd_type                 cmd,
   output ocfi_pkg::dp_status_type              st
);
   import ocfi_pkg::*;

   // captured request
   logic                      action_ff;
   logic signed [COORD_W-1:0] point_x_ff, point_y_ff, point_z_ff;
   logic [LEVEL_W-1:0]        depth_ff;
   logic [LEVEL_W-1:0]        depth_in;

   // walk state
   logic [EXTENT_W-1:0] rel_x_ff, rel_y_ff, rel_z_ff;
   logic [EXTENT_W-1:0] rel_x_in, rel_y_in, rel_z_in;
   logic [EXTENT_W-1:0] half_x_ff, half_y_ff, half_z_ff;
   logic [EXTENT_W-1:0] half_x_in, half_y_in, half_z_in;
   logic [OCT_W-1:0]    off_ff, off_in;
   logic [NODE_W-1:0]   node_ff;
   logic [LEVEL_W-1:0]  level_ff;
   logic [COUNT_W-1:0]  nodes_used_ff;

   // bounds check
   logic signed [REL_W-1:0] rel_x, rel_y, rel_z;

   // node pool memory
   row_type           mem [POOL_NODES];
   row_type           rd_row_ff;
   row_type           link_row;
   row_type           wr_data;
   logic [NODE_W-1:0] wr_addr;
   logic              wr_en;
   logic [NODE_W-1:0] entry;

   // response register
   logic              out_valid_ff;
   logic [NODE_W-1:0] out_node_ff;
   status_type        out_status_ff;

   // deep requests stop at the last level
   assign depth_in = (in_target_depth > LEVEL_W'(MAX_LEVELS - 1)) ?
                     LEVEL_W'(MAX_LEVELS - 1) : in_target_depth;

   // point relative to the tree origin
   assign rel_x = {point_x_ff[COORD_W-1], point_x_ff} - {cfg.origin_x[COORD_W-1], cfg.origin_x};
   assign rel_y = {point_y_ff[COORD_W-1], point_y_ff} - {cfg.origin_y[COORD_W-1], cfg.origin_y};
   assign rel_z = {point_z_ff[COORD_W-1], point_z_ff} - {cfg.origin_z[COORD_W-1], cfg.origin_z};

   // octant step: halve each extent, pick the upper half when past the middle
   always_comb begin
      half_x_in = half_x_ff >> 1;
      half_y_in = half_y_ff >> 1;
      half_z_in = half_z_ff >> 1;
      off_in    = '0;
      rel_x_in  = rel_x_ff;
      rel_y_in  = rel_y_ff;
      rel_z_in  = rel_z_ff;
      if (rel_x_ff > half_x_in) begin
         off_in[0] = 1'b1;
         rel_x_in  = rel_x_ff - half_x_in;
      end
      if (rel_y_ff > half_y_in) begin
         off_in[1] = 1'b1;
         rel_y_in  = rel_y_ff - half_y_in;
      end
      if (rel_z_ff > half_z_in) begin
         off_in[2] = 1'b1;
         rel_z_in  = rel_z_ff - half_z_in;
      end
   end

   // request capture and walk registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= in_action;
         point_x_ff <= in_point_x;
         point_y_ff <= in_point_y;
         point_z_ff <= in_point_z;
         depth_ff   <= depth_in;
      end
      if (cmd.walk_init) begin
         rel_x_ff  <= rel_x[EXTENT_W-1:0];
         rel_y_ff  <= rel_y[EXTENT_W-1:0];
         rel_z_ff  <= rel_z[EXTENT_W-1:0];
         half_x_ff <= cfg.extent_x;
         half_y_ff <= cfg.extent_y;
         half_z_ff <= cfg.extent_z;
      end else if (cmd.step) begin
         rel_x_ff  <= rel_x_in;
         rel_y_ff  <= rel_y_in;
         rel_z_ff  <= rel_z_in;
         half_x_ff <= half_x_in;
         half_y_ff <= half_y_in;
         half_z_ff <= half_z_in;
         off_ff    <= off_in;
      end
   end

   // current node and level
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff  <= '0;
         level_ff <= '0;
      end else if (cmd.capture) begin
         node_ff  <= '0;
         level_ff <= '0;
      end else begin
         if (cmd.follow) begin
            node_ff <= entry;
         end else if (cmd.link) begin
            node_ff <= nodes_used_ff[NODE_W-1:0];
         end
         if (cmd.level_inc) begin
            level_ff <= level_ff + LEVEL_W'(1);
         end
      end
   end

   // allocation counter, the root is always taken
   always_ff @(posedge clock) begin
      if (reset || cmd.row0_clear) begin
         nodes_used_ff <= COUNT_W'(1);
      end else if (cmd.spawn) begin
         nodes_used_ff <= nodes_used_ff + COUNT_W'(1);
      end
   end

   // parent row with the new child linked in
   always_comb begin
      link_row         = rd_row_ff;
      link_row[off_ff] = nodes_used_ff[NODE_W-1:0];
   end

   // memory write select; a fresh node gets an empty row
   always_comb begin
      wr_en   = cmd.row0_clear || cmd.link || cmd.spawn;
      wr_addr = node_ff;
      wr_data = '0;
      priority if (cmd.row0_clear) begin
         wr_addr = '0;
      end else if (cmd.link) begin
         wr_data = link_row;
      end else begin
         wr_data = '0;
      end
   end

   // node pool, one row per node
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.step) begin
         rd_row_ff <= mem[node_ff];
      end
   end

   assign entry = rd_row_ff[off_ff];

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_status_ff <= cmd.emit_status;
         out_node_ff   <= (cmd.emit_status == ST_OK) ? node_ff : '0;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_node_index = out_node_ff;
   assign out_status     = out_status_ff;

   // status to the controller
   assign st.is_clear   = action_ff;
   assign st.below      = rel_x[REL_W-1] || rel_y[REL_W-1] || rel_z[REL_W-1];
   assign st.beyond     = ($signed(rel_x) > $signed({2'b00, cfg.extent_x})) ||
                          ($signed(rel_y) > $signed({2'b00, cfg.extent_y})) ||
                          ($signed(rel_z) > $signed({2'b00, cfg.extent_z}));
   assign st.hit        = (entry != '0);
   assign st.pool_full  = (nodes_used_ff >= COUNT_W'(POOL_NODES));
   assign st.last_level = (level_ff == depth_ff);
   assign st.out_free   = !out_valid_ff || out_ready;

   // a response is only loaded when the register is free
   `OCFI_ASSERT_IMPL(a_emit_free, clock, reset, cmd.emit, st.out_free)
   // linking a child is always followed by clearing its row
   `OCFI_ASSERT_NEXT(a_link_spawn, clock, reset, cmd.link, cmd.spawn)
   // the walk only visits allocated nodes
   `OCFI_ASSERT_IMPL(a_node_alloc, clock, reset, cmd.step, COUNT_W'(node_ff) < nodes_used_ff)
   // allocation count stays within the pool
   `OCFI_ASSERT_IMPL(a_count_range, clock, reset, 1'b1,
                     nodes_used_ff != '0 && nodes_used_ff <= COUNT_W'(POOL_NODES))

endmodule

>>> design/ocfi_ctrl.sv
// ----------------------------------------------------------------------------
// ocfi_ctrl
// Sequencer for the walk: bounds check, per-level lookup, child allocation,
// root row clears and hand-off to the response register.
// ----------------------------------------------------------------------------
module ocfi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ocfi_pkg::dp_status_type st,
   output ocfi_pkg::dp_cmd_type    cmd
);
   import ocfi_pkg::*;

   ctrl_state_type state_ff, state_in;
   status_type     result_ff, result_in;

   // next state and result code
   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      unique case (state_ff)
         S_INIT: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (st.is_clear) begin
               state_in  = S_RESULT;
               result_in = ST_OK;
            end else if (st.below) begin
               state_in  = S_RESULT;
               result_in = ST_BELOW;
            end else if (st.beyond) begin
               state_in  = S_RESULT;
               result_in = ST_BEYOND;
            end else begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            priority if (st.hit && st.last_level) begin
               state_in  = S_RESULT;
               result_in = ST_OK;
            end else if (st.hit) begin
               state_in = S_STEP;
            end else if (st.pool_full) begin
               state_in  = S_RESULT;
               result_in = ST_FULL;
            end else begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            state_in = S_SPAWN;
         end
         S_SPAWN: begin
            if (st.last_level) begin
               state_in  = S_RESULT;
               result_in = ST_OK;
            end else begin
               state_in = S_STEP;
            end
         end
         S_RESULT: begin
            if (st.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd             = '0;
      cmd.emit_status = result_ff;
      req_ready       = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.row0_clear = 1'b1;
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_CHECK: begin
            if (st.is_clear) begin
               cmd.row0_clear = 1'b1;
            end else if (!st.below && !st.beyond) begin
               cmd.walk_init = 1'b1;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
         end
         S_EVAL: begin
            if (st.hit) begin
               cmd.follow    = 1'b1;
               cmd.level_inc = !st.last_level;
            end
         end
         S_LINK: begin
            cmd.link = 1'b1;
         end
         S_SPAWN: begin
            cmd.spawn     = 1'b1;
            cmd.level_inc = !st.last_level;
         end
         S_RESULT: begin
            cmd.emit = st.out_free;
         end
         default: cmd = '0;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         result_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         result_ff <= result_in;
      end
   end

endmodule

>>> design/octree_node_find_or_insert.sv
// ----------------------------------------------------------------------------
// octree_node_find_or_insert
// Walks an octree held in a 4096-node pool from the root, creating missing
// children, and returns the node reached or a failure status.
// ----------------------------------------------------------------------------
// One request at a time. A find-or-insert request is accepted in S_IDLE and
// bounds-checked in S_CHECK, then walks each level with a row read of the node
// pool and the octant select (S_STEP, S_EVAL), plus a link into the parent row
// and the emptying of the new row (S_LINK, S_SPAWN) for each child created,
// and the response is loaded in S_RESULT. Out-of-bounds and clear requests go
// from S_CHECK straight to S_RESULT. The node pool is a single-port row memory,
// one row of eight child links per node; a new node's row is emptied when it
// is allocated, so only the root row is written after reset and by a clear.
// The response register lets the next request be accepted while a response
// waits.
// ----------------------------------------------------------------------------
module octree_node_find_or_insert (
   input  logic                             clock,
   input  logic                             reset,
   ocfi_req_if.sink                         req_ch,
   ocfi_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [ocfi_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ocfi_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ocfi_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type st;
   logic          req_ready;

   // configuration registers
   ocfi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   ocfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // datapath and node pool
   ocfi_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_action       (req_ch.action),
      .in_point_x      (req_ch.point_x),
      .in_point_y      (req_ch.point_y),
      .in_point_z      (req_ch.point_z),
      .in_target_depth (req_ch.target_depth),
      .out_ready       (rsp_ch.ready),
      .out_valid       (rsp_ch.valid),
      .out_node_index  (rsp_ch.node_index),
      .out_status      (rsp_ch.status),
      .cmd             (cmd),
      .st              (st)
   );

endmodule

>>> verif/tb_octree_node_find_or_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_octree_node_find_or_insert
// Self-checking bench for the octree find-or-insert block. Requests go in on
// the request channel with random gaps. A scoreboard keeps its own copy of the
// child table and node count, predicts the node and status of every accepted
// request, and compares each response in order. The run moves through several
// tree placements: extreme origins, full and unit extents, and a zero extent.
// It also fills the pool, holds the response side off for a long stretch,
// and drains the block in mid phase in two of the phases.
// ----------------------------------------------------------------------------
module tb_octree_node_find_or_insert;
   import ocfi_pkg::*;

   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     HOLD_CYCLES    = 400;
   localparam int     HISTORY_DEPTH  = 32;
   localparam longint COORD_MIN      = -64'sd2147483648;
   localparam longint COORD_MAX      = 64'sd2147483647;
   localparam longint EXTENT_MAX     = 64'sd2147483647;
   localparam longint EXTENT_ONE     = 64'sd65536;

   // indexes past the last register, ignored by the block
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct {
      bit                 action;
      int                 px;
      int                 py;
      int                 pz;
      bit [LEVEL_W-1:0]   depth;
   } node_req_type;

   typedef struct {
      bit [NODE_W-1:0]    node;
      status_type         status;
   } node_rsp_type;

   // tracks the tree contents and the responses still owed
   class octree_scoreboard;
      bit [NODE_W-1:0] child_links [POOL_NODES*OCTANTS];
      int unsigned     nodes_used;
      longint          org_x, org_y, org_z;
      longint          ext_x, ext_y, ext_z;
      node_rsp_type    owed_rsp_q[$];
      int              mismatches;
      int              checked;
      int              requests;
      int              clears;
      int              out_of_bounds;
      int              pool_full_hits;

      function new();
         empty_pool();
         org_x = 0; org_y = 0; org_z = 0;
         ext_x = EXTENT_ONE; ext_y = EXTENT_ONE; ext_z = EXTENT_ONE;
      endfunction

      function void empty_pool();
         foreach (child_links[i]) child_links[i] = '0;
         nodes_used = 1;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_ORIGIN_X: org_x = longint'(signed'(data));
            REG_ORIGIN_Y: org_y = longint'(signed'(data));
            REG_ORIGIN_Z: org_z = longint'(signed'(data));
            REG_EXTENT_X: ext_x = longint'(data[EXTENT_W-1:0]);
            REG_EXTENT_Y: ext_y = longint'(data[EXTENT_W-1:0]);
            REG_EXTENT_Z: ext_z = longint'(data[EXTENT_W-1:0]);
            default: ;
         endcase
      endfunction

      // descend from the root, allocating missing children
      function node_rsp_type walk_tree(node_req_type r);
         node_rsp_type res;
         longint       rx, ry, rz, hx, hy, hz;
         int unsigned  node, slot;
         int           lvl;
         bit [2:0]     octant;
         res.node   = '0;
         res.status = ST_OK;
         if (r.action) begin
            empty_pool();
            return res;
         end
         rx = longint'(r.px) - org_x;
         ry = longint'(r.py) - org_y;
         rz = longint'(r.pz) - org_z;
         // below origin wins over beyond extent
         if (rx < 0 || ry < 0 || rz < 0) begin
            res.status = ST_BELOW;
            return res;
         end
         if (rx > ext_x || ry > ext_y || rz > ext_z) begin
            res.status = ST_BEYOND;
            return res;
         end
         hx = ext_x; hy = ext_y; hz = ext_z;
         node = 0;
         for (lvl = 0; lvl <= int'(r.depth); lvl++) begin
            hx = hx / 2; hy = hy / 2; hz = hz / 2;
            octant = '0;
            if (rx > hx) begin octant[0] = 1'b1; rx -= hx; end
            if (ry > hy) begin octant[1] = 1'b1; ry -= hy; end
            if (rz > hz) begin octant[2] = 1'b1; rz -= hz; end
            slot = node * OCTANTS + octant;
            if (child_links[slot] == '0) begin
               // nodes made earlier in this walk stay allocated
               if (nodes_used >= POOL_NODES) begin
                  res.status = ST_FULL;
                  return res;
               end
               child_links[slot] = NODE_W'(nodes_used);
               nodes_used++;
            end
            node = child_links[slot];
         end
         res.node = NODE_W'(node);
         return res;
      endfunction

      function void note_request(node_req_type r);
         node_rsp_type res;
         res = walk_tree(r);
         requests++;
         if (r.action) clears++;
         if (res.status == ST_BELOW || res.status == ST_BEYOND) out_of_bounds++;
         if (res.status == ST_FULL) pool_full_hits++;
         owed_rsp_q.push_back(res);
      endfunction

      function void check_response(logic [NODE_W-1:0] node, logic [STATUS_W-1:0] status);
         node_rsp_type exp;
         if (owed_rsp_q.size() == 0) begin
            if (mismatches < 10)
               $display("response with nothing pending: node %0d status %0d", node, status);
            mismatches++;
            return;
         end
         exp = owed_rsp_q.pop_front();
         if (node !== exp.node || status !== exp.status) begin
            if (mismatches < 10)
               $display("mismatch on response %0d: expected node %0d status %s,",
                        checked, exp.node, exp.status.name(),
                        " got node %0d status %0d", node, status);
            mismatches++;
         end
         checked++;
      endfunction

      function int pending();
         return owed_rsp_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ocfi_req_if req_bus ();
   ocfi_rsp_if rsp_bus ();

   octree_scoreboard sb = new();

   // stimulus mirror of the tree placement
   longint       cur_org [3];
   longint       cur_ext [3];
   node_req_type recent_q[$];
   bit           calm;
   bit           hold_rsp;
   int           settings_used;

   octree_node_find_or_insert u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // one register write, taken at the next edge
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   // write the whole placement; bit 31 of an extent word is junk
   task automatic load_config(longint ox, longint oy, longint oz,
                              longint ex, longint ey, longint ez);
      write_reg(REG_ORIGIN_X, ox[CSR_DATA_W-1:0]);
      write_reg(REG_ORIGIN_Y, oy[CSR_DATA_W-1:0]);
      write_reg(REG_ORIGIN_Z, oz[CSR_DATA_W-1:0]);
      write_reg(REG_EXTENT_X, {1'($urandom_range(0, 1)), ex[EXTENT_W-1:0]});
      write_reg(REG_EXTENT_Y, {1'($urandom_range(0, 1)), ey[EXTENT_W-1:0]});
      write_reg(REG_EXTENT_Z, {1'($urandom_range(0, 1)), ez[EXTENT_W-1:0]});
      write_reg(REG_SPARE_LO, $urandom);
      write_reg(REG_SPARE_HI, $urandom);
      csr_wr_en <= 1'b0;
      cur_org[0] = ox; cur_org[1] = oy; cur_org[2] = oz;
      cur_ext[0] = ex; cur_ext[1] = ey; cur_ext[2] = ez;
      settings_used++;
   endtask

   // offer one request and hold it until taken
   task automatic send_request(node_req_type r);
      req_bus.valid        <= 1'b1;
      req_bus.action       <= r.action;
      req_bus.point_x      <= r.px;
      req_bus.point_y      <= r.py;
      req_bus.point_z      <= r.pz;
      req_bus.target_depth <= r.depth;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
   endtask

   // idle the request side now and then, mostly briefly
   task automatic sender_gap();
      int gap;
      if (!calm && $urandom_range(0, 2) == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic offer_point(bit act, int x, int y, int z, int depth);
      node_req_type r;
      r.action = act;
      r.px     = x;
      r.py     = y;
      r.pz     = z;
      r.depth  = LEVEL_W'(depth);
      send_request(r);
      sender_gap();
   endtask

   // stop sending and wait for every owed response
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // coordinate inside the volume, biased to the corners and the midpoint
   function automatic int axis_inside(int a);
      longint lim, rel;
      lim = cur_ext[a];
      if (cur_org[a] + lim > COORD_MAX) lim = COORD_MAX - cur_org[a];
      case ($urandom_range(0, 9))
         0: rel = 0;
         1: rel = lim;
         2: rel = lim / 2;
         3: rel = (lim / 2 + 1 <= lim) ? lim / 2 + 1 : lim;
         default: rel = longint'($urandom_range(0, 32'(lim)));
      endcase
      return int'(cur_org[a] + rel);
   endfunction

   // coordinate on or just off the volume edge; may wrap
   function automatic int axis_edge(int a);
      case ($urandom_range(0, 2))
         0: return int'(cur_org[a] - 1);
         1: return int'(cur_org[a] + cur_ext[a] + 1);
         default: return int'(cur_org[a] + cur_ext[a]);
      endcase
   endfunction

   function automatic node_req_type make_request(int clear_pm, int depth_lo);
      node_req_type r;
      int           pick, ax;
      r.action = 1'b0;
      r.px     = $urandom;
      r.py     = $urandom;
      r.pz     = $urandom;
      r.depth  = LEVEL_W'($urandom_range(depth_lo, 15));
      pick     = $urandom_range(0, 99);
      if ($urandom_range(0, 999) < clear_pm) begin
         r.action = 1'b1;
      end else if (pick < 15 && recent_q.size() > 0) begin
         // revisit a known point, usually a find
         r       = recent_q[$urandom_range(0, recent_q.size() - 1)];
         r.depth = LEVEL_W'($urandom_range(depth_lo, 15));
      end else if (pick < 92) begin
         r.px = axis_inside(0);
         r.py = axis_inside(1);
         r.pz = axis_inside(2);
         if (pick < 80) begin
            recent_q.push_back(r);
            if (recent_q.size() > HISTORY_DEPTH) void'(recent_q.pop_front());
         end else begin
            ax = $urandom_range(0, 2);
            case (ax)
               0: r.px = axis_edge(0);
               1: r.py = axis_edge(1);
               default: r.pz = axis_edge(2);
            endcase
         end
      end
      return r;
   endfunction

   task automatic run_phase(int count, int clear_pm, int depth_lo, bit quiet,
                            int hold_at, int drain_at);
      calm = quiet;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) hold_rsp = 1'b1;
         if (i == drain_at) drain();
         send_request(make_request(clear_pm, depth_lo));
         sender_gap();
      end
      drain();
      repeat (6) @(posedge clock);
   endtask

   // response side: random stalls, long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.node_index, rsp_bus.status);
         if (hold_rsp) begin
            hold_rsp  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 49))
               0:       stall_left = $urandom_range(30, 80);
               1, 2, 3: stall_left = $urandom_range(4, 15);
               default: stall_left = $urandom_range(0, 2);
            endcase
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on handshake progress
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("no handshake for %0d cycles, %0d responses pending",
               WATCHDOG_LIMIT, sb.pending());
      $display("Regression FAIL");
      $finish;
   end

   // main sequence
   initial begin
      int failures;
      calm          = 1'b0;
      hold_rsp      = 1'b0;
      settings_used = 0;
      cur_org[0] = 0; cur_org[1] = 0; cur_org[2] = 0;
      cur_ext[0] = EXTENT_ONE; cur_ext[1] = EXTENT_ONE; cur_ext[2] = EXTENT_ONE;
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.action       <= 1'b0;
      req_bus.point_x      <= '0;
      req_bus.point_y      <= '0;
      req_bus.point_z      <= '0;
      req_bus.target_depth <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests on the reset placement
      offer_point(1'b1, 0, 0, 0, 0);
      offer_point(1'b0, 0, 0, 0, 0);
      offer_point(1'b0, 0, 0, 0, 0);
      offer_point(1'b0, 0, 0, 0, 15);
      offer_point(1'b0, 65536, 65536, 65536, 15);
      offer_point(1'b0, 65537, 0, 0, 3);
      offer_point(1'b0, 0, 65537, 0, 3);
      offer_point(1'b0, 0, 0, 65537, 3);
      offer_point(1'b0, -1, 0, 0, 2);
      offer_point(1'b0, 0, -1, 0, 2);
      offer_point(1'b0, 0, 0, -1, 2);
      offer_point(1'b0, -1, 65537, 0, 0);
      offer_point(1'b0, int'(COORD_MIN), int'(COORD_MAX), 0, 0);
      offer_point(1'b0, int'(COORD_MAX), 0, 0, 5);
      offer_point(1'b0, 32768, 32769, 40000, 7);
      offer_point(1'b0, 32769, 32768, 32768, 9);
      offer_point(1'b0, 32768, 32768, 32769, 9);
      offer_point(1'b0, 65536, 0, 65536, 4);
      offer_point(1'b1, int'(COORD_MAX), int'(COORD_MIN), -1, 15);
      offer_point(1'b0, 0, 0, 0, 0);
      for (int i = 0; i < 3; i++)
         offer_point(1'b0, $urandom_range(0, 65536), $urandom_range(0, 65536),
                     $urandom_range(0, 65536), $urandom_range(0, 15));
      drain();
      repeat (6) @(posedge clock);

      // offset placement, no idling on either side
      load_config(0, -(64'sd1 <<< 20), 64'sd1 <<< 18,
                  64'sd1 <<< 20, EXTENT_ONE, 3 * EXTENT_ONE);
      run_phase(100, 0, 0, 1'b1, -1, -1);

      // widest volume, deep walks until the pool runs out, long hold-off
      load_config(COORD_MIN, COORD_MIN, COORD_MIN, EXTENT_MAX, EXTENT_MAX, EXTENT_MAX);
      run_phase(340, 0, 14, 1'b0, 50, -1);

      // top corner origin with unit extent
      load_config(COORD_MAX, COORD_MAX, COORD_MAX, 1, 1, 1);
      run_phase(60, 30, 0, 1'b0, -1, -1);

      // zero extent on x, tiny extents elsewhere, mid-phase drain
      load_config(longint'(signed'($urandom)), longint'(signed'($urandom)),
                  longint'(signed'($urandom)), 0,
                  $urandom_range(1, 1023), $urandom_range(1, 1023));
      run_phase(120, 10, 0, 1'b0, -1, 60);

      // random placement
      load_config(longint'(signed'($urandom)), longint'(signed'($urandom)),
                  longint'(signed'($urandom)), $urandom_range(1, 32'h7fff_ffff),
                  $urandom_range(1, 32'h7fff_ffff), $urandom_range(1, 1 << 20));
      run_phase(200, 10, 0, 1'b0, 150, 100);

      repeat (80) @(posedge clock);
      failures = sb.mismatches;
      if (sb.pending() > 0) begin
         $display("%0d responses never arrived", sb.pending());
         failures += sb.pending();
      end
      $display("covered %0d requests over %0d tree placements: %0d clears, %0d out of bounds",
               sb.requests, settings_used + 1, sb.clears, sb.out_of_bounds);
      $display("%0d responses checked, %0d pool-full results, %0d mismatches",
               sb.checked, sb.pool_full_hits, sb.mismatches);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/ocfi_pkg.sv
design/ocfi_if.sv
design/ocfi_csr.sv
design/ocfi_dpath.sv
design/ocfi_ctrl.sv
design/octree_node_find_or_insert.sv
verif/tb_octree_node_find_or_insert.sv
